### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SCS_ASSERT_SAME(label, ante, cons)
`define SCS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/scs_pkg.sv
`timescale 1ns / 1ps
package scs_pkg;

  localparam int MAX_LINE_CHARS = 1024;
  localparam int POS_W          = 11;
  localparam int IDX_W          = 10;
  localparam int LINE_W         = 16;
  localparam int CHAR_W         = 8;
  localparam int DEPTH_W        = 16;

  localparam logic [POS_W-1:0] POS_NONE = '1;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 16'sh8000;

  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_CHARS    = 2'd0;
  localparam logic [1:0] CFG_SKIP_PREPROC = 2'd1;

  typedef struct packed {
    logic [POS_W-1:0] min_chars;
    logic             skip_preproc;
  } scs_cfg_t;

  // Per-line scan state plus the block-comment depth carried across lines.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic                      prev_star;
    logic [POS_W-1:0]          text_pos;
    logic                      prev_slash;
    logic                      cut_found;
    logic [POS_W-1:0]          cut_pos;
    logic [POS_W-1:0]          first_nb;
    logic [POS_W-1:0]          last_nb;
    logic [POS_W-1:0]          last_nb_before;
    logic                      lead_hash;
  } scs_line_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              in_text;
    logic [IDX_W-1:0]  text_index;
    logic              line_end;
    logic              line_kept;
    logic [POS_W-1:0]  cleaned_length;
    logic [POS_W-1:0]  trimmed_length;
    logic [LINE_W-1:0] line_number;
  } scs_res_t;

  typedef struct packed {
    scs_line_t st;
    scs_res_t  res;
  } scs_step_t;

  // Results handed to the output queue for one input beat.
  typedef struct packed {
    logic [1:0] cnt;
    scs_res_t   r0;
    scs_res_t   r1;
  } scs_push_t;

  function automatic scs_line_t scs_clear(logic signed [DEPTH_W-1:0] depth);
    scs_line_t s;
    s          = '0;
    s.depth    = depth;
    s.first_nb = POS_NONE;
    return s;
  endfunction

  // One byte through the comment scanner: nv/n give the next byte of the line.
  function automatic scs_step_t scs_process(scs_line_t st, logic [CHAR_W-1:0] c,
                                            logic nv, logic [CHAR_W-1:0] n);
    scs_step_t        r;
    logic             kept;
    logic [POS_W-1:0] k;
    logic [POS_W-1:0] k_prev;
    r      = '0;
    r.st   = st;
    k      = st.text_pos;
    k_prev = k - POS_W'(1);
    if (c == CH_SLASH && nv && n == CH_STAR && st.depth != DEPTH_MAX) begin
      r.st.depth = st.depth + 16'sd1;
    end
    kept = (r.st.depth <= 16'sd0) && (k < POS_W'(MAX_LINE_CHARS));
    if (kept) begin
      if (!st.cut_found) begin
        if (c == CH_SLASH && st.prev_slash) begin
          r.st.cut_found = 1'b1;
          r.st.cut_pos   = k_prev;
          r.st.last_nb   = st.last_nb_before;
          if (st.first_nb == k_prev) begin
            r.st.first_nb  = POS_NONE;
            r.st.lead_hash = 1'b0;
          end
        end else begin
          if (c != CH_SPACE && c != CH_TAB) begin
            if (st.first_nb == POS_NONE) begin
              r.st.first_nb  = k;
              r.st.lead_hash = (c == CH_HASH);
            end
            r.st.last_nb_before = st.last_nb;
            r.st.last_nb        = k;
          end
          r.st.prev_slash = (c == CH_SLASH);
        end
      end
      r.st.text_pos = k + POS_W'(1);
    end
    if (st.prev_star && c == CH_SLASH && r.st.depth != DEPTH_MIN) begin
      r.st.depth = r.st.depth - 16'sd1;
    end
    r.st.prev_star    = (c == CH_STAR);
    r.res.out_char    = c;
    r.res.in_text     = kept;
    r.res.text_index  = kept ? k[IDX_W-1:0] : '0;
    return r;
  endfunction

  // Adds the line verdict to the result of the last byte of a line.
  function automatic scs_res_t scs_verdict(scs_step_t s, scs_cfg_t cfg);
    scs_res_t         r;
    logic [POS_W-1:0] trimmed;
    r = s.res;
    if (s.st.first_nb == POS_NONE) begin
      trimmed = '0;
    end else begin
      trimmed = s.st.last_nb - s.st.first_nb + POS_W'(1);
    end
    r.line_end       = 1'b1;
    r.cleaned_length = s.st.cut_found ? s.st.cut_pos : s.st.text_pos;
    r.trimmed_length = trimmed;
    r.line_kept      = !(cfg.skip_preproc && s.st.lead_hash) && (trimmed >= cfg.min_chars);
    return r;
  endfunction

endpackage

### rtl/core/scs_filter.sv
`timescale 1ns / 1ps
module scs_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scs_pkg::scs_cfg_t          cfg,
  input  logic                       beat,
  input  logic [scs_pkg::CHAR_W-1:0] char_code,
  input  logic                       last_in_line,
  output scs_pkg::scs_push_t         push
);
  import scs_pkg::*;

  scs_line_t         line_r, line_nxt;
  logic [CHAR_W-1:0] held_char_r, held_char_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [LINE_W-1:0] line_cnt_r, line_cnt_nxt;

  scs_step_t step_a, step_b;
  scs_line_t mid;
  scs_res_t  res_a, res_b;

  // The held byte is finished with the incoming byte as lookahead, then the
  // incoming byte itself if it closes the line.
  always_comb begin
    step_a = scs_process(line_r, held_char_r, 1'b1, char_code);
    mid    = held_valid_r ? step_a.st : line_r;
    step_b = scs_process(mid, char_code, 1'b0, '0);
    res_a  = step_a.res;
    res_a.line_number = line_cnt_r;
    res_b  = scs_verdict(step_b, cfg);
    res_b.line_number = line_cnt_r;

    push.cnt = beat ? ({1'b0, held_valid_r} + {1'b0, last_in_line}) : 2'd0;
    push.r0  = held_valid_r ? res_a : res_b;
    push.r1  = res_b;

    line_nxt       = line_r;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    line_cnt_nxt   = line_cnt_r;
    if (beat) begin
      if (last_in_line) begin
        line_nxt       = scs_clear(step_b.st.depth);
        held_valid_nxt = 1'b0;
        line_cnt_nxt   = line_cnt_r + LINE_W'(1);
      end else begin
        line_nxt       = mid;
        held_char_nxt  = char_code;
        held_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r       <= scs_clear('0);
      held_valid_r <= 1'b0;
      line_cnt_r   <= '0;
    end else begin
      line_r       <= line_nxt;
      held_valid_r <= held_valid_nxt;
      line_cnt_r   <= line_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_char_r <= held_char_nxt;
  end

endmodule

### rtl/core/scs_out_queue.sv
`timescale 1ns / 1ps
module scs_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  scs_pkg::scs_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output scs_pkg::scs_res_t  head
);
  import scs_pkg::*;

  localparam int OQ_DEPTH = 4;
  localparam int CNT_W    = $clog2(OQ_DEPTH + 1);

  scs_res_t         slot_r   [OQ_DEPTH];
  scs_res_t         slot_nxt [OQ_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] base;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign head      = slot_r[0];
  assign pop       = out_valid && out_ready;
  // Space for the two results a closing beat can bring.
  assign room      = (count_r <= CNT_W'(OQ_DEPTH - 2));

  // Shift toward the head on a pop, then append behind the survivors.
  always_comb begin
    base = count_r - CNT_W'(pop);
    for (int i = 0; i < OQ_DEPTH; i++) begin
      if (pop && i < OQ_DEPTH - 1) begin
        slot_nxt[i] = slot_r[i + 1];
      end else begin
        slot_nxt[i] = slot_r[i];
      end
      if (push.cnt != 2'd0 && CNT_W'(i) == base) begin
        slot_nxt[i] = push.r0;
      end
      if (push.cnt == 2'd2 && CNT_W'(i) == base + CNT_W'(1)) begin
        slot_nxt[i] = push.r1;
      end
    end
    count_nxt = base + CNT_W'(push.cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

endmodule

### rtl/core/source_comment_strip_line_filter_core.sv
`timescale 1ns / 1ps
// A result is registered in the output queue: a byte that is not last in its
// line is pushed on the beat of the next byte of its line; a line-closing byte
// is pushed on its own beat, behind the held byte when one goes first.
// Throughput: one input beat and one result beat per cycle; input stalls
// while more than two results wait. Reset (rst_n low, synchronous) empties the
// queue, clears depth, line state and line counter, loads min_chars 3, skip 0.
`include "assert_macros.svh"
module source_comment_strip_line_filter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input byte channel.
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [scs_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_last_in_line,
  // Result channel.
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [scs_pkg::CHAR_W-1:0] out_char,
  output logic                       out_in_text,
  output logic [scs_pkg::IDX_W-1:0]  out_text_index,
  output logic                       out_line_end,
  output logic                       out_line_kept,
  output logic [scs_pkg::POS_W-1:0]  out_cleaned_length,
  output logic [scs_pkg::POS_W-1:0]  out_trimmed_length,
  output logic [scs_pkg::LINE_W-1:0] out_line_number,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [scs_pkg::POS_W-1:0]  cfg_data
);
  import scs_pkg::*;

  scs_cfg_t  cfg_r, cfg_nxt;
  scs_push_t push;
  scs_res_t  head;
  logic      room;
  logic      in_beat;

  // Configuration is always taken; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_CHARS:    cfg_nxt.min_chars    = cfg_data;
        CFG_SKIP_PREPROC: cfg_nxt.skip_preproc = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_chars    <= POS_W'(3);
      cfg_r.skip_preproc <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A byte is taken whenever the queue has space for two results, so the
  // scanner keeps going while an earlier result waits on out_ready.
  assign in_ready = room;
  assign in_beat  = in_valid && in_ready;

  // Scanner: holds one byte of lookahead for the comment-open test and
  // carries the block-comment depth and the per-line verdict state.
  scs_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .beat         (in_beat),
    .char_code    (in_char_code),
    .last_in_line (in_last_in_line),
    .push         (push)
  );

  // Result queue: registered output, decouples the two handshakes.
  scs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_char           = head.out_char;
  assign out_in_text        = head.in_text;
  assign out_text_index     = head.text_index;
  assign out_line_end       = head.line_end;
  assign out_line_kept      = head.line_kept;
  assign out_cleaned_length = head.cleaned_length;
  assign out_trimmed_length = head.trimmed_length;
  assign out_line_number    = head.line_number;

  // Verdict fields are only nonzero on the closing beat of a line.
  `SCS_ASSERT_SAME(a_verdict_only_at_end, out_valid && !out_line_end, !out_line_kept && out_cleaned_length == '0 && out_trimmed_length == '0)
  // Trimming can never lengthen the cleaned text.
  `SCS_ASSERT_SAME(a_trim_within_clean, out_valid && out_line_end, out_trimmed_length <= out_cleaned_length)
  // Bytes removed by comment stripping carry no text position.
  `SCS_ASSERT_SAME(a_index_only_in_text, out_valid && !out_in_text, out_text_index == '0)
  // A line-closing byte always leaves a result waiting in the queue.
  `SCS_ASSERT_NEXT(a_line_end_queued, in_valid && in_ready && in_last_in_line, out_valid)

endmodule

### sim/scs_line_checker.sv
`timescale 1ns / 1ps
module scs_line_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [scs_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_last_in_line,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [scs_pkg::CHAR_W-1:0] out_char,
  input  logic                       out_in_text,
  input  logic [scs_pkg::IDX_W-1:0]  out_text_index,
  input  logic                       out_line_end,
  input  logic                       out_line_kept,
  input  logic [scs_pkg::POS_W-1:0]  out_cleaned_length,
  input  logic [scs_pkg::POS_W-1:0]  out_trimmed_length,
  input  logic [scs_pkg::LINE_W-1:0] out_line_number,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [scs_pkg::POS_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending_count
);
  import scs_pkg::*;

  localparam int REPORT_CAP = 100;

  // Register copies.
  logic [POS_W-1:0]          min_len;
  logic                      drop_hash_lines;

  // Scanner state: the depth and the line counter survive a line end.
  logic signed [DEPTH_W-1:0] depth;
  logic                      star_seen;
  logic [CHAR_W-1:0]         held_byte;
  logic                      held;
  logic [POS_W-1:0]          pos;
  logic                      slash_seen;
  logic                      cut_seen;
  logic [POS_W-1:0]          cut_at;
  logic [POS_W-1:0]          first_nb;
  logic [POS_W-1:0]          last_nb;
  logic [POS_W-1:0]          last_nb_prev;
  logic                      hash_lead;
  logic [LINE_W-1:0]         line_no;

  scs_res_t                  line_results_q[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic clear_line_state();
    held         = 1'b0;
    held_byte    = '0;
    pos          = '0;
    slash_seen   = 1'b0;
    cut_seen     = 1'b0;
    cut_at       = '0;
    first_nb     = POS_NONE;
    last_nb      = '0;
    last_nb_prev = '0;
    hash_lead    = 1'b0;
    star_seen    = 1'b0;
  endtask

  // Runs one byte through the comment scanner; nv/nxt give the byte after it.
  task automatic scan_byte(input logic [CHAR_W-1:0] c, input logic nv,
                           input logic [CHAR_W-1:0] nxt, output scs_res_t r);
    logic kept;
    r = '0;
    if (c == CH_SLASH && nv && nxt == CH_STAR && depth != DEPTH_MAX) begin
      depth = depth + 16'sd1;
    end
    kept = (depth <= 16'sd0) && (pos < POS_W'(MAX_LINE_CHARS));
    r.out_char    = c;
    r.in_text     = kept;
    r.line_number = line_no;
    if (kept) begin
      r.text_index = pos[IDX_W-1:0];
      if (!cut_seen) begin
        if (c == CH_SLASH && slash_seen) begin
          cut_seen = 1'b1;
          cut_at   = pos - POS_W'(1);
          last_nb  = last_nb_prev;
          if (first_nb == pos - POS_W'(1)) begin
            first_nb  = POS_NONE;
            hash_lead = 1'b0;
          end
        end else begin
          if (c != CH_SPACE && c != CH_TAB) begin
            if (first_nb == POS_NONE) begin
              first_nb  = pos;
              hash_lead = (c == CH_HASH);
            end
            last_nb_prev = last_nb;
            last_nb      = pos;
          end
          slash_seen = (c == CH_SLASH);
        end
      end
      pos = pos + POS_W'(1);
    end
    if (star_seen && c == CH_SLASH && depth != DEPTH_MIN) begin
      depth = depth - 16'sd1;
    end
    star_seen = (c == CH_STAR);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (fail_count < REPORT_CAP) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    scs_res_t         r;
    scs_res_t         want;
    logic [POS_W-1:0] trimmed;
    if (!rst_n) begin
      min_len         = POS_W'(3);
      drop_hash_lines = 1'b0;
      depth           = '0;
      line_no         = '0;
      clear_line_state();
      line_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN_CHARS) begin
          min_len = cfg_data;
        end else if (cfg_index == CFG_SKIP_PREPROC) begin
          drop_hash_lines = cfg_data[0];
        end
      end

      // A result is registered in the queue before it can leave, so the pop comes first.
      if (out_valid && out_ready) begin
        if (line_results_q.size() == 0) begin
          if (fail_count < REPORT_CAP) begin
            $error("result beat with no expectation: char %0d line %0d",
                   out_char, out_line_number);
          end
          fail_count++;
        end else begin
          want = line_results_q.pop_front();
          check_field("out_char", want.out_char, out_char);
          check_field("in_text", want.in_text, out_in_text);
          check_field("text_index", want.text_index, out_text_index);
          check_field("line_end", want.line_end, out_line_end);
          check_field("line_kept", want.line_kept, out_line_kept);
          check_field("cleaned_length", want.cleaned_length, out_cleaned_length);
          check_field("trimmed_length", want.trimmed_length, out_trimmed_length);
          check_field("line_number", want.line_number, out_line_number);
        end
      end

      if (in_valid && in_ready) begin
        if (held) begin
          scan_byte(held_byte, 1'b1, in_char_code, r);
          line_results_q.insert(line_results_q.size(), r);
        end
        if (!in_last_in_line) begin
          held_byte = in_char_code;
          held      = 1'b1;
        end else begin
          scan_byte(in_char_code, 1'b0, '0, r);
          trimmed = (first_nb == POS_NONE) ? '0 : last_nb - first_nb + POS_W'(1);
          r.line_end       = 1'b1;
          r.cleaned_length = cut_seen ? cut_at : pos;
          r.trimmed_length = trimmed;
          r.line_kept      = !(drop_hash_lines && hash_lead) && (trimmed >= min_len);
          line_results_q.insert(line_results_q.size(), r);
          line_no = line_no + LINE_W'(1);
          clear_line_state();
        end
      end
    end
    pending_count <= line_results_q.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import scs_pkg::*;

  // Receiver hold-off used to back the block up until it refuses input.
  localparam int HOLD_CYCLES   = 300;
  // Bounds on how long the end of the run may wait for the last results.
  localparam int DRAIN_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 10;
  // Rough byte budget for each random phase.
  localparam int PHASE_BYTES   = 30;
  localparam int PHASE_COUNT   = 6;
  // Two-byte units in the line that runs past the length limit.
  localparam int LONG_REPS     = 516;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              in_last_in_line = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              out_in_text;
  logic [IDX_W-1:0]  out_text_index;
  logic              out_line_end;
  logic              out_line_kept;
  logic [POS_W-1:0]  out_cleaned_length;
  logic [POS_W-1:0]  out_trimmed_length;
  logic [LINE_W-1:0] out_line_number;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [POS_W-1:0]  cfg_data = '0;

  int                fail_count;
  int                pending_count;

  // Shared between the byte source and the result sink. idle_on enables random
  // gaps on both sides; hold_req asks the sink for one long hold-off.
  bit                idle_on = 1'b0;
  bit                hold_req = 1'b0;
  // The generator's own guess of how many block comments are open. It only
  // steers the mix of openers and closers, so an inexact guess does no harm.
  int                open_guess = 0;

  source_comment_strip_line_filter_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_last_in_line    (in_last_in_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_in_text        (out_in_text),
    .out_text_index     (out_text_index),
    .out_line_end       (out_line_end),
    .out_line_kept      (out_line_kept),
    .out_cleaned_length (out_cleaned_length),
    .out_trimmed_length (out_trimmed_length),
    .out_line_number    (out_line_number),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  scs_line_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_last_in_line    (in_last_in_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_in_text        (out_in_text),
    .out_text_index     (out_text_index),
    .out_line_end       (out_line_end),
    .out_line_kept      (out_line_kept),
    .out_cleaned_length (out_cleaned_length),
    .out_trimmed_length (out_trimmed_length),
    .out_line_number    (out_line_number),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The run is cut off after a fixed time, far beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 70);
  endfunction

  // The result sink decides out_ready once per cycle at the falling edge. A
  // stall always ends in a ready cycle, so every phase of
  // the block's work sees both.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_on ? pick_idle() : 0;
      end
    end
  end

  // Offers one byte and returns at the falling edge after its beat. Valid
  // stays high afterwards, so back-to-back bytes never see a dip; the next
  // call either changes the payload or lowers valid for a gap.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    gap = idle_on ? pick_idle() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_char_code    <= c;
    in_last_in_line <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  // One line made of the same short unit over and over.
  task automatic send_repeated(input string unit, input int reps);
    for (int k = 0; k < reps; k++) begin
      for (int i = 0; i < unit.len(); i++) begin
        send_byte(unit[i], (k == reps - 1) && (i == unit.len() - 1));
      end
    end
  endtask

  // Lowers valid and waits until the checker has seen every result. Config
  // writes follow only at a line boundary, where nothing is held inside the
  // block, and after a short pause for the last result to leave it.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reprogram(input logic [POS_W-1:0] min_len, input logic skip);
    wait_drained();
    write_reg(CFG_MIN_CHARS, min_len);
    write_reg(CFG_SKIP_PREPROC, {{(POS_W-1){1'b0}}, skip});
  endtask

  // Builds one random line and sends it. Lines are short and made of
  // comment openers and closers, double slashes, hashes, blanks and text.
  // Openers come mainly when no comment is believed open and closers mainly
  // when one is, so the depth stays near zero; the rest is stray tokens and
  // raw bytes that break the sequences.
  task automatic send_random_line(output int n);
    logic [CHAR_W-1:0] line_q[$];
    int                target;
    int                r;
    target = $urandom_range(1, 24);
    if ($urandom_range(0, 4) == 0) begin
      line_q.insert(line_q.size(), CH_HASH);
    end
    while (line_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if (open_guess == 0 || r < 2) begin
          line_q.insert(line_q.size(), CH_SLASH);
          line_q.insert(line_q.size(), CH_STAR);
          open_guess++;
        end
      end else if (r < 22) begin
        if (open_guess > 0 || r < 12) begin
          line_q.insert(line_q.size(), CH_STAR);
          line_q.insert(line_q.size(), CH_SLASH);
          if (open_guess > 0) begin
            open_guess--;
          end
        end
      end else if (r < 30) begin
        line_q.insert(line_q.size(), CH_SLASH);
        line_q.insert(line_q.size(), CH_SLASH);
      end else if (r < 36) begin
        line_q.insert(line_q.size(), CH_HASH);
      end else if (r < 46) begin
        line_q.insert(line_q.size(), CH_SPACE);
      end else if (r < 52) begin
        line_q.insert(line_q.size(), CH_TAB);
      end else if (r < 58) begin
        line_q.insert(line_q.size(), $urandom_range(0, 1) ? CH_SLASH : CH_STAR);
      end else if (r < 66) begin
        line_q.insert(line_q.size(), CHAR_W'($urandom_range(0, 255)));
      end else begin
        line_q.insert(line_q.size(), CHAR_W'($urandom_range(8'h41, 8'h7A)));
      end
    end
    n = line_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte(line_q[i], i == n - 1);
    end
  endtask

  initial begin : stimulus
    int n;
    int sent;
    int wait_cycles;

    // Synchronous reset, held low from the start and released once.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines with hash lines dropped and a low length floor.
    idle_on = 1'b0;
    reprogram(POS_W'(2), 1'b1);
    send_byte(8'h00, 1'b1);          // smallest byte, one-byte line
    send_byte(8'hFF, 1'b1);          // largest byte
    send_text(" #x");                // hash after a leading blank
    send_text("a//");                // double slash at the very end of the line
    send_text("//");                 // line that is nothing but a line comment
    send_text("/*b*/c");             // block comment inside one line
    send_text("/*");                 // comment left open across the line end
    send_text("x*/y");               // closed on the next line
    send_text("*/");                 // stray closer drives the depth below zero
    send_text("/*z");                // opener only brings it back to zero
    send_text("\tq\t");              // tabs on both sides of the text

    // The sink holds off for a long stretch while bytes keep coming, so the
    // output queue fills and the block stops taking input. Afterwards the
    // source pauses until every result has come back.
    hold_req = 1'b1;
    sent = 0;
    while (sent < 40) begin
      send_random_line(n);
      sent += n;
    end
    wait_drained();

    // Random phases, each with its own register setting, the extremes of
    // the length floor among them. One phase runs with no idling at all.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0:       reprogram(POS_W'(0), 1'b0);
        1:       reprogram(POS_W'(MAX_LINE_CHARS), 1'b1);
        2:       reprogram(POS_W'(3), 1'b0);
        default: reprogram(POS_W'($urandom_range(1, 12)), 1'($urandom_range(0, 1)));
      endcase
      idle_on = (phase != 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_random_line(n);
        sent += n;
      end
    end

    // Closers pull any open comment back out, then one line runs past the
    // length limit under the highest length floor: its first 1024 bytes
    // count and the rest fall outside the text.
    idle_on = 1'b0;
    reprogram(POS_W'(MAX_LINE_CHARS), 1'b0);
    send_repeated("*/x", 10);
    send_repeated("ab", LONG_REPS);
    send_text("ab c//d");

    // Wait for the last results, with a bound, then let the block settle.
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_count != 0) begin
      $error("%0d expected results never arrived", pending_count);
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
